FILE: rtl/circular_deque_assert.svh
// Assertion macros shared by the circular deque RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset
`define CDQ_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("circular_deque assertion failed");
// Next-cycle implication
`define CDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("circular_deque assertion failed");
`else
`define CDQ_ASSERT(lbl, clk, rstn, ante, cons)
`define CDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/cdq_pkg.sv
// Types and codes of the circular deque.
// No dependencies; circular_deque, cdq_mem, cdq_ptr and cdq_out import it.
package cdq_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH_REAR  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_REAR   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_CLEAR      = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 6;

    // Per-operation outcome, captured when the transaction is accepted
    typedef struct packed {
        logic    pop_ok;
        t_status status;
    } t_op_info;

    // Queue flags after the operation
    typedef struct packed {
        logic             is_full;
        logic             is_empty;
        logic [OCC_W-1:0] occupancy;
    } t_flags;

    // Result payload
    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        t_status                  status;
        logic                     is_full;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
    } t_rsp;

endpackage

FILE: rtl/cdq_if.sv
// Request and response channel interfaces of the circular deque.
// No dependencies.
interface cdq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] data_in;

    modport source (output valid, output mode, output data_in, input ready);
    modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface cdq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic               is_full;
    logic               is_empty;
    logic [5:0]         occupancy;

    modport source (output valid, output data_out, output status, output is_full,
                    output is_empty, output occupancy, input ready);
    modport sink   (input valid, input data_out, input status, input is_full,
                    input is_empty, input occupancy, output ready);
endinterface

FILE: rtl/circular_deque.sv
// Circular deque: double-ended queue of DEPTH 32-bit entries in one RAM.
// Depends on cdq_pkg, cdq_if, cdq_mem, cdq_ptr and cdq_out.
//
// Channels: i_req carries one operation per transaction (mode: push rear,
// push front, pop rear, pop front, clear; data_in for pushes). o_rsp returns
// exactly one result per request: popped value, status, full/empty flags
// and occupancy after the operation. Both use valid/ready handshakes.
// The result is loaded into the result register after the registered read
// of the entry RAM that the accepted request starts.
// A new request is not taken while that RAM read is in flight: the read
// must complete before the next operation is decoded.
// A rejected push (full) or pop (empty) leaves the queue unchanged and
// reports the status code. Codes above clear are no operation.
// Reset: synchronous, active low; pointers and count go to zero and the
// queue reads empty. RAM contents are not cleared and need no sweep.
// Receiver stall: the result register holds; a new request is taken in
// the cycle the pending result is consumed.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cdq_req_if.sink   i_req,
    cdq_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);

    logic              accept;
    logic              we;
    logic [AW-1:0]     addr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;
    t_op_info          info;
    t_flags            flags;
    t_rsp              rsp;

    cdq_ptr #(.DEPTH(DEPTH)) u_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_mode  (t_mode'(i_req.mode)),
        .i_data  (i_req.data_in),
        .o_we    (we),
        .o_addr  (addr),
        .o_wdata (wdata),
        .o_info  (info),
        .o_flags (flags)
    );

    cdq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    cdq_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .i_rsp_ready(o_rsp.ready),
        .i_info     (info),
        .i_flags    (flags),
        .i_rdata    (rdata),
        .o_req_ready(i_req.ready),
        .o_accept   (accept),
        .o_rsp_valid(o_rsp.valid),
        .o_rsp      (rsp)
    );

    // Drive the response payload
    assign o_rsp.data_out  = rsp.data_out;
    assign o_rsp.status    = rsp.status;
    assign o_rsp.is_full   = rsp.is_full;
    assign o_rsp.is_empty  = rsp.is_empty;
    assign o_rsp.occupancy = rsp.occupancy;

endmodule

FILE: rtl/cdq_mem.sv
// Entry store of the circular deque: one-port synchronous RAM.
// Depends on cdq_pkg; read data is registered.
module cdq_mem
    import cdq_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write the entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cdq_ptr.sv
// Head, tail and count registers of the circular deque, and the
// operation decode that drives the entry RAM. Depends on cdq_pkg.
`include "circular_deque_assert.svh"
module cdq_ptr
    import cdq_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_mode             i_mode,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_we,
    output logic [AW-1:0]     o_addr,
    output logic [DATA_W-1:0] o_wdata,
    output t_op_info          o_info,
    output t_flags            o_flags
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic          full;
    logic          empty;
    logic          one_left;
    logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;

    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign one_left = (r_count == CW'(1));

    // Wrap pointers at the ends of the store
    assign head_next = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST : r_head - 1'b1;
    assign tail_next = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST : r_tail - 1'b1;

    // Decode the operation, pick the RAM access and the new pointers
    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        o_we           = 1'b0;
        o_addr         = r_head;
        o_info.pop_ok  = 1'b0;
        o_info.status  = ST_OK;
        if (i_accept) begin
            unique case (i_mode) inside
                MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
                    if (full) begin
                        o_info.status = ST_FULL;
                    end else begin
                        o_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        if (empty) begin
                            n_head = '0;
                            n_tail = '0;
                            o_addr = '0;
                        end else if (i_mode == MODE_PUSH_REAR) begin
                            n_tail = tail_next;
                            o_addr = tail_next;
                        end else begin
                            n_head = head_prev;
                            o_addr = head_prev;
                        end
                    end
                end
                MODE_POP_REAR, MODE_POP_FRONT: begin
                    if (empty) begin
                        o_info.status = ST_EMPTY;
                    end else begin
                        o_info.pop_ok = 1'b1;
                        o_addr = (i_mode == MODE_POP_REAR) ? r_tail : r_head;
                        if (one_left) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end else begin
                            if (i_mode == MODE_POP_REAR) begin
                                n_tail = tail_prev;
                            end else begin
                                n_head = head_next;
                            end
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                MODE_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_wdata = i_data;

    // Report flags from the current state
    assign o_flags.is_full   = full;
    assign o_flags.is_empty  = empty;
    assign o_flags.occupancy = OCC_W'(r_count);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    `CDQ_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `CDQ_ASSERT(a_empty_ptrs, i_clk, i_rst_n, empty, (r_head == '0) && (r_tail == '0))
    `CDQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_accept && o_we, r_count == $past(r_count) + 1'b1)

endmodule

FILE: rtl/cdq_out.sv
// Handshake control and result register of the circular deque.
// Depends on cdq_pkg; merges RAM read data with the operation outcome.
`include "circular_deque_assert.svh"
module cdq_out
    import cdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_rsp_ready,
    input  t_op_info          i_info,
    input  t_flags            i_flags,
    input  logic [DATA_W-1:0] i_rdata,
    output logic              o_req_ready,
    output logic              o_accept,
    output logic              o_rsp_valid,
    output t_rsp              o_rsp
);

    logic     r_pend;
    logic     r_valid;
    t_op_info r_info;
    t_rsp     r_rsp;

    // Take a transaction only out of reset, with no read in flight and a free result slot
    assign o_req_ready = i_rst_n && !r_pend && (!r_valid || i_rsp_ready);
    assign o_accept    = i_req_valid && o_req_ready;

    // Track the read in flight and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_pend <= o_accept;
            if (r_pend) begin
                r_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the outcome until the read data arrives, then load the result
    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_info <= i_info;
        end
        if (r_pend) begin
            r_rsp.data_out  <= r_info.pop_ok ? i_rdata : '0;
            r_rsp.status    <= r_info.status;
            r_rsp.is_full   <= i_flags.is_full;
            r_rsp.is_empty  <= i_flags.is_empty;
            r_rsp.occupancy <= i_flags.occupancy;
        end
    end

    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

    `CDQ_ASSERT_NEXT(a_pend_after_accept, i_clk, i_rst_n, o_accept, r_pend)
    `CDQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, r_pend, r_valid)

endmodule
